### src/crb_pkg.sv
package crb_pkg;

  // Function values: signed, fixed 55 bits
  localparam int VW  = 55;
  // Saturating sums are formed two bits wider
  localparam int SVW = VW + 2;
  // Shared multiplier: 32x32 limbs, 64-bit operand magnitudes
  localparam int LW  = 32;
  localparam int OPW = 2 * LW;
  localparam int PW  = 2 * OPW;

  localparam int TOL_W   = 32;
  localparam int STEP_W  = 7;
  localparam int STAT_W  = 2;
  localparam int CFG_DW  = 32;
  localparam int CFG_IW  = 1;

  localparam logic signed [VW-1:0] VMAX = {1'b0, {(VW-1){1'b1}}};
  localparam logic signed [VW-1:0] VMIN = {1'b1, {(VW-1){1'b0}}};

  localparam logic [STEP_W-1:0] CAP_MAX   = 7'd64;
  localparam logic [STEP_W-1:0] CAP_RESET = 7'd60;
  localparam logic [TOL_W-1:0]  TOL_RESET = 32'd4;

  // Finish status codes
  localparam logic [STAT_W-1:0] STAT_TOL  = 2'd0;
  localparam logic [STAT_W-1:0] STAT_ZERO = 2'd1;
  localparam logic [STAT_W-1:0] STAT_CAP  = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IW-1:0] REG_TOL = 1'b0;
  localparam logic [CFG_IW-1:0] REG_CAP = 1'b1;

  function automatic logic [OPW-1:0] mag_of(input logic signed [VW-1:0] v);
    logic [VW-1:0] u;
    u = v[VW-1] ? VW'(-v) : VW'(v);
    return {{(OPW-VW){1'b0}}, u};
  endfunction

  // Clamp a widened sum back to the value range
  function automatic logic signed [VW-1:0] sat_v(input logic signed [SVW-1:0] v);
    if ((&v[SVW-1:VW-1]) || !(|v[SVW-1:VW-1]))
      return v[VW-1:0];
    else if (v[SVW-1])
      return VMIN;
    else
      return VMAX;
  endfunction

  function automatic logic opposite(input logic signed [VW-1:0] a,
                                    input logic signed [VW-1:0] b);
    logic a_pos, b_pos;
    a_pos = !a[VW-1] && (|a);
    b_pos = !b[VW-1] && (|b);
    return (a[VW-1] && b_pos) || (a_pos && b[VW-1]);
  endfunction

endpackage

### src/crb_if.sv
interface crb_in_if #(parameter int XW = 40);
  logic                 valid;
  logic                 ready;
  logic signed [XW-1:0] first_end;
  logic signed [XW-1:0] second_end;

  modport source(output valid, first_end, second_end, input ready);
  modport sink(input valid, first_end, second_end, output ready);
endinterface

interface crb_out_if import crb_pkg::*; #(parameter int XW = 40);
  logic                 valid;
  logic                 ready;
  logic signed [XW-1:0] root_estimate;
  logic [STEP_W-1:0]    steps_used;
  logic [STAT_W-1:0]    finish_status;
  logic                 flat_ends;

  modport source(output valid, root_estimate, steps_used, finish_status, flat_ends,
                 input ready);
  modport sink(input valid, root_estimate, steps_used, finish_status, flat_ends,
               output ready);
endinterface

### src/crb_mul.sv
module crb_mul import crb_pkg::*; #(
  parameter int FRAC_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [OPW-1:0]       a_mag,
  input  logic [OPW-1:0]       b_mag,
  input  logic                 neg,
  output logic                 done,
  output logic signed [VW-1:0] product
);

  localparam logic [2:0] PH_LAST_MUL = 3'd3;
  localparam logic [2:0] PH_LAST_ACC = 3'd4;
  localparam logic [2:0] PH_FIN      = 3'd5;

  logic           busy;
  logic [2:0]     phase;
  logic [OPW-1:0] a_reg, b_reg;
  logic           neg_reg;
  logic [OPW-1:0] pp;
  logic [1:0]     pp_pos;
  logic [PW-1:0]  acc;
  logic [PW-1:0]  pp_shifted;
  logic [LW-1:0]  a_limb, b_limb;

  logic                 big;
  logic [VW-2:0]        mag_q;
  logic                 rem_nz;
  logic [VW-1:0]        rounded;
  logic signed [VW-1:0] fin;

  assign a_limb = phase[1] ? a_reg[OPW-1:LW] : a_reg[LW-1:0];
  assign b_limb = phase[0] ? b_reg[OPW-1:LW] : b_reg[LW-1:0];

  always_comb begin
    case (pp_pos)
      2'd0:    pp_shifted = {{(PW-OPW){1'b0}}, pp};
      2'd1:    pp_shifted = {{(PW-OPW-LW){1'b0}}, pp, {LW{1'b0}}};
      default: pp_shifted = {pp, {(PW-OPW){1'b0}}};
    endcase
  end

  // Floor-shift by FRAC_BITS, then clamp to the value range
  always_comb begin
    big     = |acc[PW-1:FRAC_BITS+VW-1];
    mag_q   = acc[FRAC_BITS+VW-2:FRAC_BITS];
    rem_nz  = |acc[FRAC_BITS-1:0];
    rounded = {1'b0, mag_q} + {{(VW-1){1'b0}}, rem_nz};
    if (!neg_reg)
      fin = big ? VMAX : $signed({1'b0, mag_q});
    else if (big || rounded[VW-1])
      fin = VMIN;
    else
      fin = $signed(-rounded);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      phase <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        phase <= '0;
      end else if (busy) begin
        phase <= phase + 3'd1;
        if (phase == PH_FIN) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_reg   <= a_mag;
      b_reg   <= b_mag;
      neg_reg <= neg;
      acc     <= '0;
    end else if (busy) begin
      if (phase <= PH_LAST_MUL) begin
        pp     <= OPW'(a_limb) * OPW'(b_limb);
        pp_pos <= {1'b0, phase[1]} + {1'b0, phase[0]};
      end
      if (phase != 3'd0 && phase <= PH_LAST_ACC)
        acc <= acc + pp_shifted;
      if (phase == PH_FIN)
        product <= fin;
    end
  end

endmodule

### src/crb_poly.sv
module crb_poly import crb_pkg::*; #(
  parameter int FRAC_BITS = 32,
  parameter int XW        = 40
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic signed [XW-1:0] x,
  output logic                 done,
  output logic signed [VW-1:0] value
);

  localparam logic [2:0] PS_IDLE = 3'd0;
  localparam logic [2:0] PS_SQ   = 3'd1;
  localparam logic [2:0] PS_CUBE = 3'd2;
  localparam logic [2:0] PS_SUM1 = 3'd3;
  localparam logic [2:0] PS_SUM2 = 3'd4;

  localparam logic signed [VW-1:0] TEN = VW'(64'd10 << FRAC_BITS);

  logic [2:0]           state;
  logic signed [VW-1:0] x_reg;
  logic signed [VW-1:0] x_ext;
  logic signed [VW-1:0] sq;
  logic signed [VW-1:0] cube;
  logic signed [VW-1:0] sum1;
  logic signed [VW-1:0] four_sq;

  logic                 mul_start;
  logic [OPW-1:0]       mul_a, mul_b;
  logic                 mul_neg;
  logic                 mul_done;
  logic signed [VW-1:0] mul_product;

  assign x_ext   = VW'(x);
  assign four_sq = sat_v($signed({sq, 2'b00}));

  // Square first, then square times x on the same multiplier
  always_comb begin
    mul_start = (state == PS_IDLE && start) || (state == PS_SQ && mul_done);
    if (state == PS_IDLE) begin
      mul_a   = mag_of(x_ext);
      mul_b   = mag_of(x_ext);
      mul_neg = 1'b0;
    end else begin
      mul_a   = mag_of(mul_product);
      mul_b   = mag_of(x_reg);
      mul_neg = mul_product[VW-1] != x_reg[VW-1];
    end
  end

  crb_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a_mag   (mul_a),
    .b_mag   (mul_b),
    .neg     (mul_neg),
    .done    (mul_done),
    .product (mul_product)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= PS_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        PS_IDLE: if (start) state <= PS_SQ;
        PS_SQ:   if (mul_done) state <= PS_CUBE;
        PS_CUBE: if (mul_done) state <= PS_SUM1;
        PS_SUM1: state <= PS_SUM2;
        PS_SUM2: begin
          state <= PS_IDLE;
          done  <= 1'b1;
        end
        default: state <= PS_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == PS_IDLE && start)
      x_reg <= x_ext;
    if (state == PS_SQ && mul_done)
      sq <= mul_product;
    if (state == PS_CUBE && mul_done)
      cube <= mul_product;
    if (state == PS_SUM1)
      sum1 <= sat_v(SVW'(cube) + SVW'(four_sq));
    if (state == PS_SUM2)
      value <= sat_v(SVW'(sum1) - SVW'(TEN));
  end

endmodule

### src/cubic_root_bisection_unit.sv
// Bisection search for a root of p(x) = x^3 + 4x^2 - 10 over one interval per
// transaction. Endpoints and the estimate are signed Q(INT_BITS).(FRAC_BITS);
// the interfaces on in_ch and out_ch must carry XW = INT_BITS + FRAC_BITS.
//
// in_ch:  valid/ready; first_end, second_end. Taken only while the search unit
//         is idle, so one interval is in flight at a time.
// out_ch: valid/ready; root_estimate, steps_used, finish_status, flat_ends.
//         A result sits in an output register; a new interval is accepted
//         while it waits, and a stalled receiver only holds up the next result.
// cfg:    cfg_write/cfg_index/cfg_data set width_tolerance (index 0) and
//         iteration_cap (index 1). Write only while no search is running.
//
// Evaluation: each evaluation of p runs on the shared 32x32 multiplier
// (two products of four partial products each, plus two saturating adds).
// Reset: clears the sequencer and output valid; tolerance returns to 4 and the
// iteration cap to 60.
module cubic_root_bisection_unit import crb_pkg::*; #(
  parameter int FRAC_BITS = 32,
  parameter int INT_BITS  = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_data,
  crb_in_if.sink            in_ch,
  crb_out_if.source         out_ch
);

  localparam int XW = INT_BITS + FRAC_BITS;
  // Width for comparing an endpoint distance against the tolerance
  localparam int DW = (XW + 1 > TOL_W) ? XW + 1 : TOL_W;

  localparam logic [2:0] ST_IDLE      = 3'd0;
  localparam logic [2:0] ST_EVAL_LO   = 3'd1;
  localparam logic [2:0] ST_EVAL_HI   = 3'd2;
  localparam logic [2:0] ST_CHECK     = 3'd3;
  localparam logic [2:0] ST_MID_START = 3'd4;
  localparam logic [2:0] ST_MID_WAIT  = 3'd5;
  localparam logic [2:0] ST_FINISH    = 3'd6;

  logic [2:0]        state;
  logic [TOL_W-1:0]  width_tolerance;
  logic [STEP_W-1:0] iteration_cap;
  logic [STEP_W-1:0] cap_eff;

  // Working values of the current search
  logic signed [XW-1:0] low_end, high_end, midpoint;
  logic signed [VW-1:0] low_end_value, high_end_value;
  logic [STEP_W-1:0]    step_count;
  logic                 flat_seen;
  logic [STAT_W-1:0]    status;

  // Result register
  logic                 out_valid;
  logic signed [XW-1:0] out_root;
  logic [STEP_W-1:0]    out_steps;
  logic [STAT_W-1:0]    out_status;
  logic                 out_flat;

  logic                 accept_in;
  logic                 out_load;
  logic                 poly_start;
  logic signed [XW-1:0] poly_x;
  logic                 poly_done;
  logic signed [VW-1:0] poly_value;

  logic signed [XW:0]   lo_w, hi_w, mid_sum;
  logic [XW:0]          width_now;
  logic                 width_gt;
  logic signed [VW:0]   lov_w, hiv_w;
  logic [VW:0]          value_gap;
  logic                 flat_now;
  logic                 cap_left;

  assign accept_in   = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state == ST_IDLE);
  assign out_load    = (state == ST_FINISH) && (!out_valid || out_ch.ready);

  assign cap_eff  = (iteration_cap > CAP_MAX) ? CAP_MAX : iteration_cap;
  assign cap_left = step_count < cap_eff;

  // Interval width against the tolerance, and midpoint rounded toward -inf
  always_comb begin
    lo_w      = (XW + 1)'(low_end);
    hi_w      = (XW + 1)'(high_end);
    width_now = (lo_w > hi_w) ? (XW + 1)'(lo_w - hi_w) : (XW + 1)'(hi_w - lo_w);
    width_gt  = DW'(width_now) > DW'(width_tolerance);
    mid_sum   = lo_w + hi_w;
  end

  // Flat-ends warning: end values closer than the tolerance
  always_comb begin
    lov_w     = (VW + 1)'(low_end_value);
    hiv_w     = (VW + 1)'(high_end_value);
    value_gap = (lov_w > hiv_w) ? (VW + 1)'(lov_w - hiv_w) : (VW + 1)'(hiv_w - lov_w);
    flat_now  = value_gap < (VW + 1)'(width_tolerance);
  end

  // One evaluation unit serves both endpoints and every midpoint
  always_comb begin
    poly_start = accept_in || (state == ST_EVAL_LO && poly_done) || (state == ST_MID_START);
    case (state)
      ST_IDLE:    poly_x = XW'(in_ch.first_end);
      ST_EVAL_LO: poly_x = high_end;
      default:    poly_x = midpoint;
    endcase
  end

  crb_poly #(.FRAC_BITS(FRAC_BITS), .XW(XW)) u_poly (
    .clk   (clk),
    .rst   (rst),
    .start (poly_start),
    .x     (poly_x),
    .done  (poly_done),
    .value (poly_value)
  );

  // Sequencer, configuration and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      out_valid       <= 1'b0;
      width_tolerance <= TOL_RESET;
      iteration_cap   <= CAP_RESET;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          REG_TOL: width_tolerance <= cfg_data;
          REG_CAP: iteration_cap   <= cfg_data[STEP_W-1:0];
          default: ;
        endcase
      end

      if (out_load)
        out_valid <= 1'b1;
      else if (out_ch.ready)
        out_valid <= 1'b0;

      unique case (state)
        ST_IDLE:      if (accept_in) state <= ST_EVAL_LO;
        ST_EVAL_LO:   if (poly_done) state <= ST_EVAL_HI;
        ST_EVAL_HI:   if (poly_done) state <= ST_CHECK;
        ST_CHECK:     state <= (cap_left && width_gt) ? ST_MID_START : ST_FINISH;
        ST_MID_START: state <= ST_MID_WAIT;
        ST_MID_WAIT: begin
          if (poly_done)
            state <= (poly_value == '0) ? ST_FINISH : ST_CHECK;
        end
        ST_FINISH:    if (out_load) state <= ST_IDLE;
        default:      state <= ST_IDLE;
      endcase
    end
  end

  // Search datapath
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (accept_in) begin
          low_end    <= XW'(in_ch.first_end);
          high_end   <= XW'(in_ch.second_end);
          midpoint   <= XW'(in_ch.first_end);
          step_count <= '0;
          flat_seen  <= 1'b0;
        end
      end
      ST_EVAL_LO: if (poly_done) low_end_value <= poly_value;
      ST_EVAL_HI: if (poly_done) high_end_value <= poly_value;
      ST_CHECK: begin
        if (cap_left && width_gt) begin
          if (flat_now)
            flat_seen <= 1'b1;
          midpoint <= mid_sum[XW:1];
        end else begin
          status <= width_gt ? STAT_CAP : STAT_TOL;
        end
      end
      ST_MID_WAIT: begin
        if (poly_done) begin
          // Replace the endpoint whose value shares the midpoint's sign
          if (opposite(poly_value, low_end_value)) begin
            high_end       <= midpoint;
            high_end_value <= poly_value;
          end else if (opposite(poly_value, high_end_value)) begin
            low_end       <= midpoint;
            low_end_value <= poly_value;
          end
          step_count <= step_count + 7'd1;
          if (poly_value == '0)
            status <= STAT_ZERO;
        end
      end
      default: ;
    endcase

    if (out_load) begin
      out_root   <= midpoint;
      out_steps  <= step_count;
      out_status <= status;
      out_flat   <= flat_seen;
    end
  end

  assign out_ch.valid         = out_valid;
  assign out_ch.root_estimate = out_root;
  assign out_ch.steps_used    = out_steps;
  assign out_ch.finish_status = out_status;
  assign out_ch.flat_ends     = out_flat;

`ifndef NO_ASSERTIONS
  a_steps_bounded: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_steps <= CAP_MAX)
    else $error("steps_used above the hard cap");

  a_zero_needs_step: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_status == STAT_ZERO |-> out_steps != '0)
    else $error("exact-zero status without any step");

  a_poly_done_expected: assert property (@(posedge clk) disable iff (rst)
    poly_done |-> (state == ST_EVAL_LO || state == ST_EVAL_HI || state == ST_MID_WAIT))
    else $error("evaluation finished outside a wait state");

  a_result_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_FINISH)
    else $error("result raised without a finished search");
`endif

endmodule

### bench/cubic_root_bisection_checker.sv
module cubic_root_bisection_checker import crb_pkg::*; #(
  parameter int XW        = 40,
  parameter int FRAC_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IW-1:0]    cfg_index,
  input  logic [CFG_DW-1:0]    cfg_data,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic signed [XW-1:0] in_first_end,
  input  logic signed [XW-1:0] in_second_end,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic signed [XW-1:0] out_root_estimate,
  input  logic [STEP_W-1:0]    out_steps_used,
  input  logic [STAT_W-1:0]    out_finish_status,
  input  logic                 out_flat_ends,
  output int                   mismatches,
  output int                   pending_results
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [XW-1:0] first_end;
    logic signed [XW-1:0] second_end;
  } bracket_t;

  typedef struct packed {
    logic signed [XW-1:0] root_estimate;
    logic [STEP_W-1:0]    steps_used;
    logic [STAT_W-1:0]    finish_status;
    logic                 flat_ends;
  } root_report_t;

  localparam logic signed [127:0] VALUE_CEIL  = VMAX;
  localparam logic signed [127:0] VALUE_FLOOR = VMIN;
  localparam logic signed [127:0] TEN_Q       = 128'sd10 <<< FRAC_BITS;

  logic [TOL_W-1:0]  tol_reg;
  logic [STEP_W-1:0] cap_reg;
  root_report_t      root_q[$];
  root_report_t      oldest;
  root_report_t      seen;
  bracket_t          taken;
  int                mismatch_count = 0;

  function automatic logic signed [VW-1:0] clamp_value(input logic signed [127:0] v);
    if (v > VALUE_CEIL) return VMAX;
    if (v < VALUE_FLOOR) return VMIN;
    return v[VW-1:0];
  endfunction

  // Full product, floored back to FRAC_BITS fraction bits
  function automatic logic signed [VW-1:0] fixed_mul(input logic signed [VW-1:0] a,
                                                     input logic signed [VW-1:0] b);
    logic signed [127:0] wa, wb;
    wa = a;
    wb = b;
    return clamp_value((wa * wb) >>> FRAC_BITS);
  endfunction

  function automatic logic signed [VW-1:0] cubic_at(input logic signed [XW-1:0] x);
    logic signed [VW-1:0]  xv, sq, cube;
    logic signed [127:0]   wsq, wcube;
    xv = x;
    sq = fixed_mul(xv, xv);
    cube = fixed_mul(sq, xv);
    wsq = sq;
    wcube = cube;
    return clamp_value(clamp_value(wcube + clamp_value(wsq * 4)) - TEN_Q);
  endfunction

  function automatic longint distance(input longint a, input longint b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic bit signs_differ(input logic signed [VW-1:0] a,
                                      input logic signed [VW-1:0] b);
    return (a < 0 && b > 0) || (a > 0 && b < 0);
  endfunction

  function automatic root_report_t bisect(input bracket_t iv,
                                          input logic [TOL_W-1:0] tol,
                                          input logic [STEP_W-1:0] cap_setting);
    longint               lo_x, hi_x, mid_x, tol_l;
    logic signed [VW-1:0] lo_v, hi_v, mid_v;
    int                   cap, steps;
    bit                   flat, zero_hit;
    root_report_t         r;
    cap = (cap_setting > CAP_MAX) ? CAP_MAX : cap_setting;
    tol_l = tol;
    lo_x = iv.first_end;
    hi_x = iv.second_end;
    lo_v = cubic_at(iv.first_end);
    hi_v = cubic_at(iv.second_end);
    steps = 0;
    flat = 1'b0;
    zero_hit = 1'b0;
    r.root_estimate = iv.first_end;
    while (!zero_hit && steps < cap && distance(lo_x, hi_x) > tol_l) begin
      if (distance(lo_v, hi_v) < tol_l) flat = 1'b1;
      mid_x = (lo_x + hi_x) >>> 1;
      mid_v = cubic_at(mid_x[XW-1:0]);
      // move whichever end shares the midpoint's sign
      if (signs_differ(mid_v, lo_v)) begin
        hi_x = mid_x;
        hi_v = mid_v;
      end else if (signs_differ(mid_v, hi_v)) begin
        lo_x = mid_x;
        lo_v = mid_v;
      end
      steps++;
      r.root_estimate = mid_x[XW-1:0];
      if (mid_v == 0) zero_hit = 1'b1;
    end
    if (zero_hit)
      r.finish_status = STAT_ZERO;
    else if (distance(lo_x, hi_x) <= tol_l)
      r.finish_status = STAT_TOL;
    else
      r.finish_status = STAT_CAP;
    r.steps_used = steps[STEP_W-1:0];
    r.flat_ends = flat;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("ERROR at %0t ns: %s: got %0d, expected %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      tol_reg = TOL_RESET;
      cap_reg = CAP_RESET;
      root_q.delete();
    end else begin
      if (cfg_write) begin
        if (cfg_index == REG_TOL) tol_reg = cfg_data[TOL_W-1:0];
        if (cfg_index == REG_CAP) cap_reg = cfg_data[STEP_W-1:0];
      end
      if (out_valid && out_ready) begin
        seen.root_estimate = out_root_estimate;
        seen.steps_used = out_steps_used;
        seen.finish_status = out_finish_status;
        seen.flat_ends = out_flat_ends;
        if (root_q.size() == 0) begin
          report_mismatch("result with nothing outstanding, root_estimate",
                          seen.root_estimate, 0);
        end else begin
          oldest = root_q.pop_front();
          if (seen.root_estimate !== oldest.root_estimate)
            report_mismatch("root_estimate", seen.root_estimate, oldest.root_estimate);
          if (seen.steps_used !== oldest.steps_used)
            report_mismatch("steps_used", seen.steps_used, oldest.steps_used);
          if (seen.finish_status !== oldest.finish_status)
            report_mismatch("finish_status", seen.finish_status, oldest.finish_status);
          if (seen.flat_ends !== oldest.flat_ends)
            report_mismatch("flat_ends", seen.flat_ends, oldest.flat_ends);
        end
      end
      if (in_valid && in_ready) begin
        taken.first_end = in_first_end;
        taken.second_end = in_second_end;
        root_q.push_back(bisect(taken, tol_reg, cap_reg));
      end
    end
    pending_results <= root_q.size();
    mismatches <= mismatch_count;
  end

endmodule

### bench/cubic_root_bisection_unit_tb.sv
// Top of the bench for the cubic bisection unit.
//
// Intervals go in on in_ch, one result per interval comes back on out_ch. The
// checker beside the block watches both channels and the register port, keeps
// its own copy of width_tolerance and iteration_cap, works out every result
// when the interval is taken and compares fields in order. This module only
// makes traffic, owns the clock and reset, and gives the verdict.
//
// Traffic plan:
//   - a directed set under a handful of register settings: the endpoint
//     extremes, swapped ends, a bracket that hits the tolerance on the very
//     last allowed step, a cap of zero, a cap past sixty-four, brackets with
//     no sign change (run to the cap) and a flat stretch of the cubic near
//     its local maximum
//   - random phases, each with fresh register values: mostly brackets around
//     the single real root, plus full-range noise, narrow intervals near the
//     tolerance and one-sided intervals that never change sign
// One phase holds the receiver off for a long stretch while intervals keep
// coming, so the result register fills and the block stalls its input.
module cubic_root_bisection_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import crb_pkg::*;

  localparam int FRAC_BITS = 32;
  localparam int INT_BITS  = 8;
  localparam int XW        = INT_BITS + FRAC_BITS;

  localparam longint ONE_Q  = longint'(1) << FRAC_BITS;
  localparam longint X_MAX  = (longint'(1) << (XW - 1)) - 1;
  localparam longint X_MIN  = -X_MAX - 1;
  // Real root of x^3 + 4x^2 - 10 is about 1.3652300134 in Q8.32
  localparam longint ROOT_Q = 64'sd5863618259;
  // Local maximum region: p(-3.2) and p(-2.0) differ by under one unit
  localparam longint FLAT_LO = -64'sd13743895347;

  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_ITEMS   = 130;
  localparam int PRESSURE_PHASE = 3;
  localparam int RX_HOLD_CYCLES = 3000;
  localparam int DRAIN_CYCLES   = 1400;
  localparam int STALL_LIMIT    = 20000;

  logic              clk;
  logic              rst;
  logic              cfg_write;
  logic [CFG_IW-1:0] cfg_index;
  logic [CFG_DW-1:0] cfg_data;

  crb_in_if  #(.XW(XW)) in_ch();
  crb_out_if #(.XW(XW)) out_ch();

  int               error_total;
  int               results_owed;
  int               idle_cycles;
  bit               tx_idle_on;
  bit               rx_idle_on;
  bit               hold_request;
  logic [TOL_W-1:0] phase_tol;

  cubic_root_bisection_unit #(
    .FRAC_BITS(FRAC_BITS),
    .INT_BITS (INT_BITS)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  cubic_root_bisection_checker #(
    .XW       (XW),
    .FRAC_BITS(FRAC_BITS)
  ) u_checker (
    .clk              (clk),
    .rst              (rst),
    .cfg_write        (cfg_write),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_ch.valid),
    .in_ready         (in_ch.ready),
    .in_first_end     (in_ch.first_end),
    .in_second_end    (in_ch.second_end),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_root_estimate(out_ch.root_estimate),
    .out_steps_used   (out_ch.steps_used),
    .out_finish_status(out_ch.finish_status),
    .out_flat_ends    (out_ch.flat_ends),
    .mismatches       (error_total),
    .pending_results  (results_owed)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Mostly no gap or a short one, now and then a long one that lands in the
  // middle of a search.
  function automatic int pick_gap(input bit enabled);
    int roll;
    if (!enabled) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 40);
    return $urandom_range(100, 800);
  endfunction

  function automatic longint fit_x(input longint v);
    if (v > X_MAX) return X_MAX;
    if (v < X_MIN) return X_MIN;
    return v;
  endfunction

  // Registers are only touched while nothing is outstanding. Hold cfg_write
  // high across both writes and drop it once.
  task automatic configure(input logic [TOL_W-1:0] tol, input logic [STEP_W-1:0] cap);
    phase_tol = tol;
    cfg_write <= 1'b1;
    cfg_index <= REG_TOL;
    cfg_data  <= CFG_DW'(tol);
    @(posedge clk);
    cfg_index <= REG_CAP;
    cfg_data  <= CFG_DW'(cap);
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // Offer one interval and return at the edge that takes it. valid stays high
  // on return so back-to-back transactions need no extra assignment.
  task automatic send_interval(input longint a, input longint b);
    int gap;
    gap = pick_gap(tx_idle_on);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.first_end  <= a[XW-1:0];
    in_ch.second_end <= b[XW-1:0];
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Drop valid and wait until every expected result has come back.
  task automatic finish_phase();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (results_owed != 0);
  endtask

  // Receiver: random ready pattern, plus one long hold-off on request.
  initial begin : receiver
    int gap;
    out_ch.ready = 1'b0;
    wait (rst === 1'b0);
    forever begin
      if (hold_request) begin
        out_ch.ready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
      end
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk);
      gap = pick_gap(rx_idle_on);
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  // Watchdog: end the run if no transaction moves on either side for too long.
  always @(posedge clk) begin
    if (rst !== 1'b0 || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin : stimulus
    longint              a_x, b_x, offset, mag_a, mag_b;
    logic [63:0]         raw;
    logic signed [XW-1:0] rand_x;
    logic [STEP_W-1:0]   cap;
    logic [TOL_W-1:0]    tol;
    int                  kind;

    rst              = 1'b1;
    cfg_write        = 1'b0;
    cfg_index        = REG_TOL;
    cfg_data         = '0;
    in_ch.valid      = 1'b0;
    in_ch.first_end  = '0;
    in_ch.second_end = '0;
    tx_idle_on       = 1'b1;
    rx_idle_on       = 1'b1;
    hold_request     = 1'b0;
    phase_tol        = TOL_RESET;
    idle_cycles      = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Reset settings (tolerance 4, cap 60): extremes, swapped ends, zero-width
    send_interval(X_MIN, X_MAX);
    send_interval(X_MAX, X_MIN);
    send_interval(0, 0);
    send_interval(-1, 0);
    send_interval(ONE_Q, 2 * ONE_Q);
    send_interval(2 * ONE_Q, ONE_Q);
    // no sign change on either side of the root: runs to the cap
    send_interval(2 * ONE_Q, 3 * ONE_Q);
    send_interval(-5 * ONE_Q, -3 * ONE_Q);
    finish_phase();

    // Width 2^21 halves down to the tolerance exactly on step 19 of 19;
    // twice the width runs out of steps instead.
    configure(4, 19);
    send_interval(ROOT_Q - (64'sd1 << 20), ROOT_Q + (64'sd1 << 20));
    send_interval(ROOT_Q + (64'sd1 << 21), ROOT_Q - (64'sd1 << 21));
    finish_phase();

    // Cap of zero: no step, status from the starting width alone
    configure(4, 0);
    send_interval(ONE_Q, 2 * ONE_Q);
    send_interval(5, 5);
    send_interval(5, 9);
    finish_phase();

    // Cap beyond sixty-four acts as sixty-four; zero tolerance
    configure(0, 127);
    send_interval(2 * ONE_Q, 3 * ONE_Q);
    send_interval(X_MIN, X_MAX);
    send_interval(ROOT_Q, ROOT_Q + 1);
    finish_phase();

    // Widest tolerance: flat stretch near the local maximum, and a width that
    // sits exactly on the tolerance
    configure(32'hFFFF_FFFF, 64);
    send_interval(FLAT_LO, -2 * ONE_Q);
    send_interval(X_MAX, X_MIN);
    send_interval(ONE_Q, ONE_Q + 64'sh0_FFFF_FFFF);
    finish_phase();

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      tx_idle_on = ($urandom_range(0, 3) != 0);
      rx_idle_on = ($urandom_range(0, 3) != 0);
      case (phase)
        0: begin
          tol = 0;
          cap = CAP_MAX;
          tx_idle_on = 1'b1;
          rx_idle_on = 1'b1;
        end
        1: begin
          tol = 32'hFFFF_FFFF;
          cap = 1;
        end
        2: begin
          tol = $urandom;
          cap = STEP_W'($urandom_range(1, 64));
        end
        PRESSURE_PHASE: begin
          // short searches so several queue up behind the held receiver
          tol = $urandom_range(0, 255);
          cap = STEP_W'($urandom_range(2, 6));
          tx_idle_on = 1'b0;
        end
        default: begin
          case ($urandom_range(0, 3))
            0: tol = $urandom_range(0, 15);
            1: tol = 32'd1 << $urandom_range(0, 31);
            2: tol = $urandom;
            default: tol = TOL_RESET;
          endcase
          cap = ($urandom_range(0, 9) == 0) ? STEP_W'($urandom_range(65, 127))
                                            : STEP_W'($urandom_range(1, 40));
        end
      endcase
      configure(tol, cap);
      if (phase == PRESSURE_PHASE) hold_request = 1'b1;

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        kind = $urandom_range(0, 99);
        raw = {$urandom, $urandom};
        mag_a = longint'(raw >> $urandom_range(25, 63));
        raw = {$urandom, $urandom};
        mag_b = longint'(raw >> $urandom_range(25, 63));
        raw = {$urandom, $urandom};
        rand_x = raw[XW-1:0];
        if (kind < 50) begin
          // bracket around the root, random widths on each side
          a_x = fit_x(ROOT_Q - mag_a);
          b_x = fit_x(ROOT_Q + mag_b);
        end else if (kind < 70) begin
          // full-range noise
          a_x = rand_x;
          raw = {$urandom, $urandom};
          rand_x = raw[XW-1:0];
          b_x = rand_x;
        end else if (kind < 85) begin
          // narrow interval, width small or right around the tolerance
          a_x = rand_x;
          if ($urandom_range(0, 1))
            offset = $urandom_range(0, 70);
          else
            offset = longint'(phase_tol) + $urandom_range(0, 2) - 1;
          b_x = fit_x($urandom_range(0, 1) ? a_x + offset : a_x - offset);
        end else if ($urandom_range(0, 1)) begin
          // both ends above the root: no sign change
          a_x = fit_x(ROOT_Q + 1 + mag_a);
          b_x = fit_x(ROOT_Q + 1 + mag_b);
        end else begin
          a_x = fit_x(ROOT_Q - 1 - mag_a);
          b_x = fit_x(ROOT_Q - 1 - mag_b);
        end
        if ($urandom_range(0, 1))
          send_interval(a_x, b_x);
        else
          send_interval(b_x, a_x);
      end
      finish_phase();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_total == 0 && results_owed == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
